// File: sv/sorted_record_table_insert_core_defines.svh
// Assertion macros for the sorted record table insert core.
`ifndef SORTED_RECORD_TABLE_INSERT_CORE_DEFINES_SVH
`define SORTED_RECORD_TABLE_INSERT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SRTI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`define SRTI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define SRTI_ASSERT(label, prop, msg)
`define SRTI_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: sv/srti_pkg.sv
// Package: widths, codes and interface types of the sorted record table.
`timescale 1ns / 1ps
package srti_pkg;
  localparam int DEF_CAPACITY  = 128;
  localparam int DEF_KEY_BYTES = 8;
  localparam int KEY_W = 64;
  localparam int PAY_W = 39;
  localparam int IDX_W = 7;
  localparam int STS_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [STS_W-1:0] STS_INSERTED = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd1;
  localparam logic [STS_W-1:0] STS_READ_OK  = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD_IDX  = 2'd3;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;   // tag, year, month, day from msb down
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } rsp_t;
endpackage

// File: sv/srti_engine.sv
// Table memory and insert/read sequencer.
`timescale 1ns / 1ps
`include "sorted_record_table_insert_core_defines.svh"
module srti_engine
  import srti_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_BYTES = DEF_KEY_BYTES,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp,
  output logic [CW-1:0] rsp_count
);
  localparam int XW = CW + 8;
  localparam logic [KEY_W-1:0] KEY_MASK = ~{KEY_W{1'b0}} << (8 * (8 - KEY_BYTES));
  localparam int EW = KEY_W + PAY_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_RDOUT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] pos_m2;
  logic          full;
  logic          idx_ok;
  logic          place;
  logic [XW-1:0] idx_x;

  assign cnt_m1 = count - 1'b1;
  assign pos_m2 = pos - CW'(2);
  assign full   = (count == CW'(CAPACITY));
  assign idx_x  = XW'(req.index);
  assign idx_ok = idx_x < XW'(count);
  assign place  = (pos == '0) || (rd_data[KEY_W-1:0] <= key_r);

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);

  always_comb begin
    rd_addr = cnt_m1[AW-1:0];
    we      = 1'b0;
    wa      = pos[AW-1:0];
    wd      = rd_data;
    unique case (state)
      ST_IDLE: begin
        if (req.command == CMD_READ) begin
          rd_addr = idx_x[AW-1:0];
        end
      end
      ST_SHIFT: begin
        rd_addr = pos_m2[AW-1:0];
        we      = 1'b1;
        if (place) begin
          wd = {pay_r, key_r};
        end
      end
      ST_RDOUT, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.command == CMD_READ) begin
            state_next = idx_ok ? ST_RDOUT : ST_DONE;
          end else begin
            state_next = full ? ST_DONE : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: if (place) state_next = ST_DONE;
      ST_RDOUT: state_next = ST_DONE;
      ST_DONE:  if (rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SHIFT && place) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pos       <= count;
        key_r     <= req.key & KEY_MASK;
        pay_r     <= req.pay;
        rsp_count <= count;
        rsp.key   <= '0;
        rsp.pay   <= '0;
        if (req.command == CMD_READ) begin
          rsp.status <= STS_BAD_IDX;
        end else begin
          rsp.status <= STS_FULL;
        end
      end
      ST_SHIFT: begin
        pos <= pos - 1'b1;
        if (place) begin
          rsp.status <= STS_INSERTED;
          rsp_count  <= count + 1'b1;
        end
      end
      ST_RDOUT: begin
        rsp.status <= STS_READ_OK;
        rsp.key    <= rd_data[KEY_W-1:0];
        rsp.pay    <= rd_data[EW-1:KEY_W];
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  `SRTI_ASSERT_RST(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `SRTI_ASSERT_RST(a_write_in_shift, we |-> state == ST_SHIFT, "write outside shift")
  `SRTI_ASSERT_RST(a_count_step, !$past(rst) && count != $past(count) |-> count == $past(count) + 1'b1, "count moved by more than one")
endmodule

// File: sv/sorted_record_table_insert_core.sv
// Sorted record table: keeps records in ascending key order, insert and read.
// Input words arrive on s_tvalid/s_tready/s_tdata; s_tuser selects the
// command (0 insert, 1 read at index). Each input word yields one output
// word on m_tvalid/m_tready/m_tdata, with the status on m_tuser.
// An insert scans the table from the top, moving each larger entry up one
// place per cycle until the insertion point is found, through a memory with
// one write and one registered read port. An insert stays in the shift state
// until the insertion point is found; a read passes the read-out state; a
// rejected insert or out-of-range read goes straight to done. No word is taken
// until idle again. From done, the result is registered onto m_tvalid.
// A finished result sits in the output register while the next word is
// accepted; if the receiver stalls, a second result waits inside the
// sequencer and s_tready stays low until the output register frees.
// Reset empties the table by clearing the count; the memory is not cleared.
// Insert into a full table returns status 1 and leaves the table unchanged.
`timescale 1ns / 1ps
module sorted_record_table_insert_core
  import srti_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // name_key, birth_day, birth_month, birth_year, record_tag, read_index, pad
  input  logic [111:0] s_tdata,
  // command
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_key, entry_day, entry_month, entry_year, entry_tag, entry_count, pad
  output logic [111:0] m_tdata,
  // status
  output logic [1:0]   m_tuser
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 8;

  req_t          req;
  rsp_t          rsp;
  logic          rsp_valid;
  logic          rsp_ready;
  logic [CW-1:0] rsp_count;
  logic [XW-1:0] count_x;

  assign req.command = s_tuser;
  assign req.key     = s_tdata[63:0];
  assign req.pay     = s_tdata[102:64];
  assign req.index   = s_tdata[109:103];

  srti_engine #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rsp_count (rsp_count)
  );

  assign rsp_ready = !m_tvalid || m_tready;
  assign count_x   = XW'(rsp_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_tvalid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      m_tdata <= {1'b0, count_x[7:0], rsp.pay, rsp.key};
      m_tuser <= rsp.status;
    end
  end
endmodule
